// ----- src/ipsq_pkg.sv -----
// Shared types, constants and helpers for the IMU pose stillness qualifier.
`default_nettype none
package ipsq_pkg;

    localparam int FIELD_W  = 16;
    localparam int LIM_W    = 15;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int OPND_W   = 32;
    localparam int PROD_W   = 64;
    localparam int ACC_W    = 34;
    localparam int IN_W     = 6 * FIELD_W;
    localparam int OUT_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COSINE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MAGNITUDE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MAGNITUDE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_COUNT = 3'd7;

    localparam logic signed [FIELD_W-1:0] RST_TARGET_X = -16'sd13271;
    localparam logic signed [FIELD_W-1:0] RST_TARGET_Y = -16'sd9175;
    localparam logic signed [FIELD_W-1:0] RST_TARGET_Z = 16'sd3277;
    localparam logic [LIM_W-1:0] RST_MIN_COSINE    = 15'd10650;
    localparam logic [LIM_W-1:0] RST_MIN_MAGNITUDE = 15'd2048;
    localparam logic [LIM_W-1:0] RST_MAX_MAGNITUDE = 15'd2816;
    localparam logic [LIM_W-1:0] RST_RATE_LIMIT    = 15'd1024;
    localparam logic [CNT_W-1:0] RST_CONFIRM_COUNT = 4'd4;

    localparam logic [1:0] ACC_NONE = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    typedef struct packed {
        logic       issue;
        logic       neg;
        logic [1:0] op;
    } t_mac_ctl;

    typedef struct packed {
        logic update;
        logic pose;
    } t_run_req;

    typedef struct packed {
        logic [CNT_W-1:0] good_run;
        logic             confirmed;
        logic             changed;
    } t_run_res;

    function automatic logic [FIELD_W-1:0] abs16(input logic signed [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] r;
        r = v[FIELD_W-1] ? FIELD_W'(-v) : FIELD_W'(v);
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/ipsq_mac.sv -----
// Shared registered multiplier with signed accumulator.
`default_nettype none
module ipsq_mac (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire ipsq_pkg::t_mac_ctl               i_ctl,
    input  wire logic [ipsq_pkg::OPND_W-1:0]      i_a,
    input  wire logic [ipsq_pkg::OPND_W-1:0]      i_b,
    output logic [ipsq_pkg::PROD_W-1:0]           o_prod,
    output logic signed [ipsq_pkg::ACC_W-1:0]     o_acc
);

    logic [ipsq_pkg::PROD_W-1:0]       r_prod;
    logic                              r_neg;
    logic [1:0]                        r_op;
    logic [1:0]                        n_op;
    logic signed [ipsq_pkg::ACC_W-1:0] r_acc;
    logic signed [ipsq_pkg::ACC_W-1:0] n_acc;
    logic signed [ipsq_pkg::ACC_W-1:0] w_term;

    assign n_op = i_ctl.issue ? i_ctl.op : ipsq_pkg::ACC_NONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= ipsq_pkg::ACC_NONE;
        end else begin
            r_op <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_prod <= i_a * i_b;
            r_neg  <= i_ctl.neg;
        end
        r_acc <= n_acc;
    end

    always_comb begin
        w_term = r_neg ? -signed'(r_prod[ipsq_pkg::ACC_W-1:0])
                       : signed'(r_prod[ipsq_pkg::ACC_W-1:0]);
        case (r_op)
            ipsq_pkg::ACC_LOAD: n_acc = w_term;
            ipsq_pkg::ACC_ADD:  n_acc = r_acc + w_term;
            default:            n_acc = r_acc;
        endcase
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule
`default_nettype wire

// ----- src/ipsq_run.sv -----
// Consecutive good sample counter and confirmation flag.
`default_nettype none
module ipsq_run (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [ipsq_pkg::CNT_W-1:0]   i_confirm_count,
    input  wire ipsq_pkg::t_run_req           i_req,
    output ipsq_pkg::t_run_res                o_res
);

    logic [ipsq_pkg::CNT_W-1:0] r_run;
    logic [ipsq_pkg::CNT_W-1:0] n_run;
    logic                       r_conf;
    logic                       n_conf;
    logic [ipsq_pkg::CNT_W-1:0] w_need;

    always_comb begin
        w_need = (i_confirm_count == '0) ? ipsq_pkg::CNT_W'(1) : i_confirm_count;
        if (!i_req.pose) begin
            n_run = '0;
        end else if (r_run < w_need) begin
            n_run = r_run + ipsq_pkg::CNT_W'(1);
        end else begin
            n_run = r_run;
        end
        n_conf = (n_run >= w_need);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= '0;
            r_conf <= 1'b0;
        end else if (i_req.update) begin
            r_run  <= n_run;
            r_conf <= n_conf;
        end
    end

    assign o_res.good_run  = n_run;
    assign o_res.confirmed = n_conf;
    assign o_res.changed   = n_conf ^ r_conf;

endmodule
`default_nettype wire

// ----- src/imu_pose_stillness_qualifier.sv -----
// Top level: sample capture, configuration, sequencer and result register.
//
// Usage: one IMU sample per transfer on the s_axis channel, one result per
// sample on the m_axis channel. Configuration is written through
// i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// A single 32x32 multiplier with an accumulator is stepped through eleven
// operations (the three squares, the three dot terms, the squared bounds,
// the squared dot, the squared cosine and its product with |a|^2).
// A new sample is taken only once the last one has finished its sequence;
// s_axis_tready is low while a sample is in work.
// When m_axis_tready is low, the result is held in the output register; a
// second sample is still taken and worked, and it waits in its last step
// until the output register frees.
// Reset (synchronous, active low) restores the default configuration, clears
// the run counter and confirmed flag, and empties the output register.
`default_nettype none
module imu_pose_stillness_qualifier (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
    input  wire logic [ipsq_pkg::IN_W-1:0]          s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // attitude_ok, still_ok, pose_now, good_run[3:0], confirmed, changed, zero pad
    output logic [ipsq_pkg::OUT_W-1:0]              m_axis_tdata,
    input  wire logic                               i_cfg_we,
    input  wire logic [ipsq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ipsq_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam logic [3:0] STEP_AXX = 4'd0;
    localparam logic [3:0] STEP_AYY = 4'd1;
    localparam logic [3:0] STEP_AZZ = 4'd2;
    localparam logic [3:0] STEP_DX  = 4'd3;
    localparam logic [3:0] STEP_DY  = 4'd4;
    localparam logic [3:0] STEP_DZ  = 4'd5;
    localparam logic [3:0] STEP_LO  = 4'd6;
    localparam logic [3:0] STEP_HI  = 4'd7;
    localparam logic [3:0] STEP_DD  = 4'd8;
    localparam logic [3:0] STEP_C2  = 4'd9;
    localparam logic [3:0] STEP_CM  = 4'd10;
    localparam logic [3:0] STEP_FIN = 4'd11;

    localparam int FW = ipsq_pkg::FIELD_W;
    localparam int OW = ipsq_pkg::OPND_W;

    logic signed [FW-1:0]             r_tx, r_ty, r_tz;
    logic [ipsq_pkg::LIM_W-1:0]       r_min_cos, r_min_mag, r_max_mag, r_rate_lim;
    logic [ipsq_pkg::CNT_W-1:0]       r_confirm;

    logic signed [FW-1:0]             r_ax, r_ay, r_az, r_gx, r_gy, r_gz;
    logic                             r_busy;
    logic [3:0]                       r_step;
    logic [OW-1:0]                    r_mag2;
    logic                             r_lo_ok;
    logic                             r_hi_ok;
    logic                             r_dneg;
    logic [OW-1:0]                    r_ad;
    logic [ipsq_pkg::PROD_W-1:0]      r_dd;
    logic                             r_out_valid;
    logic [ipsq_pkg::OUT_W-1:0]       r_out_data;

    ipsq_pkg::t_mac_ctl               w_ctl;
    logic [OW-1:0]                    w_a, w_b;
    logic [ipsq_pkg::PROD_W-1:0]      w_prod;
    logic signed [ipsq_pkg::ACC_W-1:0] w_acc;
    ipsq_pkg::t_run_req               w_req;
    ipsq_pkg::t_run_res               w_res;
    logic                             w_in_xfer;
    logic                             w_fin;
    logic                             w_dir_ok;
    logic                             w_att_ok;
    logic                             w_still_ok;
    logic                             w_pose;

    assign s_axis_tready = !r_busy;
    assign w_in_xfer     = s_axis_tvalid && !r_busy;
    assign w_fin         = r_busy && (r_step == STEP_FIN) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx       <= ipsq_pkg::RST_TARGET_X;
            r_ty       <= ipsq_pkg::RST_TARGET_Y;
            r_tz       <= ipsq_pkg::RST_TARGET_Z;
            r_min_cos  <= ipsq_pkg::RST_MIN_COSINE;
            r_min_mag  <= ipsq_pkg::RST_MIN_MAGNITUDE;
            r_max_mag  <= ipsq_pkg::RST_MAX_MAGNITUDE;
            r_rate_lim <= ipsq_pkg::RST_RATE_LIMIT;
            r_confirm  <= ipsq_pkg::RST_CONFIRM_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ipsq_pkg::REG_TARGET_X:      r_tx       <= signed'(i_cfg_data);
                ipsq_pkg::REG_TARGET_Y:      r_ty       <= signed'(i_cfg_data);
                ipsq_pkg::REG_TARGET_Z:      r_tz       <= signed'(i_cfg_data);
                ipsq_pkg::REG_MIN_COSINE:    r_min_cos  <= i_cfg_data[ipsq_pkg::LIM_W-1:0];
                ipsq_pkg::REG_MIN_MAGNITUDE: r_min_mag  <= i_cfg_data[ipsq_pkg::LIM_W-1:0];
                ipsq_pkg::REG_MAX_MAGNITUDE: r_max_mag  <= i_cfg_data[ipsq_pkg::LIM_W-1:0];
                ipsq_pkg::REG_RATE_LIMIT:    r_rate_lim <= i_cfg_data[ipsq_pkg::LIM_W-1:0];
                ipsq_pkg::REG_CONFIRM_COUNT: r_confirm  <= i_cfg_data[ipsq_pkg::CNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= STEP_AXX;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_busy <= 1'b1;
                r_step <= STEP_AXX;
            end else if (w_fin) begin
                r_busy <= 1'b0;
            end else if (r_busy && r_step != STEP_FIN) begin
                r_step <= r_step + 4'd1;
            end
            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_ax <= signed'(s_axis_tdata[0*FW +: FW]);
            r_ay <= signed'(s_axis_tdata[1*FW +: FW]);
            r_az <= signed'(s_axis_tdata[2*FW +: FW]);
            r_gx <= signed'(s_axis_tdata[3*FW +: FW]);
            r_gy <= signed'(s_axis_tdata[4*FW +: FW]);
            r_gz <= signed'(s_axis_tdata[5*FW +: FW]);
        end
        if (r_busy && r_step == STEP_DY) begin
            r_mag2 <= w_acc[OW-1:0];
        end
        if (r_busy && r_step == STEP_HI) begin
            r_lo_ok <= ({{(ipsq_pkg::PROD_W-OW){1'b0}}, r_mag2} >= w_prod);
            r_dneg  <= w_acc[ipsq_pkg::ACC_W-1];
            r_ad    <= w_acc[ipsq_pkg::ACC_W-1] ? OW'(-w_acc) : w_acc[OW-1:0];
        end
        if (r_busy && r_step == STEP_DD) begin
            r_hi_ok <= ({{(ipsq_pkg::PROD_W-OW){1'b0}}, r_mag2} <= w_prod);
        end
        if (r_busy && r_step == STEP_C2) begin
            r_dd <= w_prod;
        end
        if (w_fin) begin
            r_out_data <= {7'b0, w_res.changed, w_res.confirmed, w_res.good_run,
                           w_pose, w_still_ok, w_att_ok};
        end
    end

    always_comb begin
        w_ctl.issue = r_busy && (r_step <= STEP_CM);
        w_ctl.neg   = 1'b0;
        w_ctl.op    = ipsq_pkg::ACC_NONE;
        w_a         = '0;
        w_b         = '0;
        unique case (r_step)
            STEP_AXX: begin
                w_a = OW'(ipsq_pkg::abs16(r_ax));
                w_b = w_a;
                w_ctl.op = ipsq_pkg::ACC_LOAD;
            end
            STEP_AYY: begin
                w_a = OW'(ipsq_pkg::abs16(r_ay));
                w_b = w_a;
                w_ctl.op = ipsq_pkg::ACC_ADD;
            end
            STEP_AZZ: begin
                w_a = OW'(ipsq_pkg::abs16(r_az));
                w_b = w_a;
                w_ctl.op = ipsq_pkg::ACC_ADD;
            end
            STEP_DX: begin
                w_a = OW'(ipsq_pkg::abs16(r_ax));
                w_b = OW'(ipsq_pkg::abs16(r_tx));
                w_ctl.neg = r_ax[FW-1] ^ r_tx[FW-1];
                w_ctl.op  = ipsq_pkg::ACC_LOAD;
            end
            STEP_DY: begin
                w_a = OW'(ipsq_pkg::abs16(r_ay));
                w_b = OW'(ipsq_pkg::abs16(r_ty));
                w_ctl.neg = r_ay[FW-1] ^ r_ty[FW-1];
                w_ctl.op  = ipsq_pkg::ACC_ADD;
            end
            STEP_DZ: begin
                w_a = OW'(ipsq_pkg::abs16(r_az));
                w_b = OW'(ipsq_pkg::abs16(r_tz));
                w_ctl.neg = r_az[FW-1] ^ r_tz[FW-1];
                w_ctl.op  = ipsq_pkg::ACC_ADD;
            end
            STEP_LO: begin
                w_a = OW'(r_min_mag);
                w_b = w_a;
            end
            STEP_HI: begin
                w_a = OW'(r_max_mag);
                w_b = w_a;
            end
            STEP_DD: begin
                w_a = r_ad;
                w_b = r_ad;
            end
            STEP_C2: begin
                w_a = OW'(r_min_cos);
                w_b = w_a;
            end
            STEP_CM: begin
                w_a = w_prod[OW-1:0];
                w_b = r_mag2;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_comb begin
        w_dir_ok   = !r_dneg && (r_dd >= w_prod);
        w_att_ok   = r_lo_ok && r_hi_ok && w_dir_ok;
        w_still_ok = (ipsq_pkg::abs16(r_gx) <= {1'b0, r_rate_lim})
                  && (ipsq_pkg::abs16(r_gy) <= {1'b0, r_rate_lim})
                  && (ipsq_pkg::abs16(r_gz) <= {1'b0, r_rate_lim});
        w_pose     = w_att_ok && w_still_ok;
        w_req.update = w_fin;
        w_req.pose   = w_pose;
    end

    ipsq_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_prod  (w_prod),
        .o_acc   (w_acc)
    );

    ipsq_run u_run (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_confirm_count (r_confirm),
        .i_req           (w_req),
        .o_res           (w_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

// ----- verif/imu_pose_stillness_qualifier_tb.sv -----
// Self-checking testbench for the IMU pose stillness qualifier: directed and random IMU samples and settings.
`default_nettype none
module imu_pose_stillness_qualifier_tb;

    typedef struct packed {
        logic                       changed;
        logic                       confirmed;
        logic [ipsq_pkg::CNT_W-1:0] good_run;
        logic                       pose_now;
        logic                       still_ok;
        logic                       attitude_ok;
    } t_pose_result;

    class t_pose_scoreboard;
        logic signed [ipsq_pkg::FIELD_W-1:0] tgt_x, tgt_y, tgt_z;
        logic [ipsq_pkg::LIM_W-1:0]          cos_min, mag_min, mag_max, rate_max;
        logic [ipsq_pkg::CNT_W-1:0]          need_cfg, run_cnt;
        logic                                conf_flag;
        t_pose_result                        awaited_results[$];
        int                                  errors;

        function new();
            tgt_x     = ipsq_pkg::RST_TARGET_X;
            tgt_y     = ipsq_pkg::RST_TARGET_Y;
            tgt_z     = ipsq_pkg::RST_TARGET_Z;
            cos_min   = ipsq_pkg::RST_MIN_COSINE;
            mag_min   = ipsq_pkg::RST_MIN_MAGNITUDE;
            mag_max   = ipsq_pkg::RST_MAX_MAGNITUDE;
            rate_max  = ipsq_pkg::RST_RATE_LIMIT;
            need_cfg  = ipsq_pkg::RST_CONFIRM_COUNT;
            run_cnt   = '0;
            conf_flag = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(logic [ipsq_pkg::CFG_IDX_W-1:0] idx,
                                logic [ipsq_pkg::CFG_DAT_W-1:0] val);
            case (idx)
                ipsq_pkg::REG_TARGET_X:      tgt_x    = val;
                ipsq_pkg::REG_TARGET_Y:      tgt_y    = val;
                ipsq_pkg::REG_TARGET_Z:      tgt_z    = val;
                ipsq_pkg::REG_MIN_COSINE:    cos_min  = val[ipsq_pkg::LIM_W-1:0];
                ipsq_pkg::REG_MIN_MAGNITUDE: mag_min  = val[ipsq_pkg::LIM_W-1:0];
                ipsq_pkg::REG_MAX_MAGNITUDE: mag_max  = val[ipsq_pkg::LIM_W-1:0];
                ipsq_pkg::REG_RATE_LIMIT:    rate_max = val[ipsq_pkg::LIM_W-1:0];
                ipsq_pkg::REG_CONFIRM_COUNT: need_cfg = val[ipsq_pkg::CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function t_pose_result qualify(logic [ipsq_pkg::IN_W-1:0] smp);
            logic signed [ipsq_pkg::FIELD_W-1:0] ax, ay, az, gx, gy, gz;
            longint                              mag2, dot;
            logic [127:0]                        mag_w, dot_w, cos_w, lo_w, hi_w;
            int                                  need, lim;
            logic                                mag_ok, dir_ok;
            t_pose_result                        res;
            ax = smp[0 +: ipsq_pkg::FIELD_W];
            ay = smp[16 +: ipsq_pkg::FIELD_W];
            az = smp[32 +: ipsq_pkg::FIELD_W];
            gx = smp[48 +: ipsq_pkg::FIELD_W];
            gy = smp[64 +: ipsq_pkg::FIELD_W];
            gz = smp[80 +: ipsq_pkg::FIELD_W];
            mag2  = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
            dot   = longint'(ax) * tgt_x + longint'(ay) * tgt_y + longint'(az) * tgt_z;
            mag_w = 128'(mag2);
            dot_w = 128'(dot < 0 ? -dot : dot);
            cos_w = 128'(cos_min);
            lo_w  = 128'(mag_min);
            hi_w  = 128'(mag_max);
            mag_ok = (mag_w >= lo_w * lo_w) && (mag_w <= hi_w * hi_w);
            dir_ok = (dot >= 0) && (dot_w * dot_w >= cos_w * cos_w * mag_w);
            lim = rate_max;
            res.attitude_ok = mag_ok && dir_ok;
            res.still_ok = ((gx < 0 ? -int'(gx) : int'(gx)) <= lim)
                        && ((gy < 0 ? -int'(gy) : int'(gy)) <= lim)
                        && ((gz < 0 ? -int'(gz) : int'(gz)) <= lim);
            res.pose_now = res.attitude_ok && res.still_ok;
            need = (need_cfg == 0) ? 1 : int'(need_cfg);
            if (res.pose_now) begin
                if (int'(run_cnt) < need)
                    run_cnt = run_cnt + 1'b1;
            end else begin
                run_cnt = '0;
            end
            res.good_run  = run_cnt;
            res.confirmed = int'(run_cnt) >= need;
            res.changed   = res.confirmed != conf_flag;
            conf_flag     = res.confirmed;
            return res;
        endfunction

        function void note_sample(logic [ipsq_pkg::IN_W-1:0] smp);
            awaited_results.push_back(qualify(smp));
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [ipsq_pkg::OUT_W-1:0] word);
            t_pose_result got, want;
            got = word[$bits(t_pose_result)-1:0];
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, word);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("attitude_ok", want.attitude_ok, got.attitude_ok);
            compare_field("still_ok", want.still_ok, got.still_ok);
            compare_field("pose_now", want.pose_now, got.pose_now);
            compare_field("good_run", want.good_run, got.good_run);
            compare_field("confirmed", want.confirmed, got.confirmed);
            compare_field("changed", want.changed, got.changed);
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
    logic [ipsq_pkg::IN_W-1:0]      s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    // attitude_ok, still_ok, pose_now, good_run[3:0], confirmed, changed, zero pad
    logic [ipsq_pkg::OUT_W-1:0]     m_axis_tdata;
    logic                           i_cfg_we;
    logic [ipsq_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [ipsq_pkg::CFG_DAT_W-1:0] i_cfg_data;

    t_pose_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int jitter;

    imu_pose_stillness_qualifier DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    initial begin
        #5_000_000;
        $display("** imu_pose_stillness_qualifier: FAILED **");
        $finish;
    end

    function automatic logic [ipsq_pkg::FIELD_W-1:0] sat16(int v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return 16'(v);
    endfunction

    function automatic int wobble();
        return int'($urandom_range(0, 2 * jitter)) - jitter;
    endfunction

    function automatic logic [ipsq_pkg::FIELD_W-1:0] signed_rate(int limit);
        int v;
        v = $urandom_range(0, limit);
        return $urandom_range(0, 1) ? sat16(-v) : sat16(v);
    endfunction

    function automatic logic [ipsq_pkg::IN_W-1:0] good_sample();
        int                        m;
        logic [ipsq_pkg::IN_W-1:0] s;
        m = $urandom_range(sb.mag_min, sb.mag_max);
        s[0 +: 16]  = sat16(int'(sb.tgt_x) * m / 16384 + wobble());
        s[16 +: 16] = sat16(int'(sb.tgt_y) * m / 16384 + wobble());
        s[32 +: 16] = sat16(int'(sb.tgt_z) * m / 16384 + wobble());
        s[48 +: 16] = signed_rate(sb.rate_max);
        s[64 +: 16] = signed_rate(sb.rate_max);
        s[80 +: 16] = signed_rate(sb.rate_max);
        return s;
    endfunction

    function automatic logic [ipsq_pkg::IN_W-1:0] broken_sample();
        logic [ipsq_pkg::IN_W-1:0] s;
        int                        axis, v;
        s = good_sample();
        case ($urandom_range(0, 2))
            0: begin
                axis = $urandom_range(0, 2);
                v = $urandom_range(int'(sb.rate_max) + 1, 32768);
                s[48 + 16 * axis +: 16] = $urandom_range(0, 1) ? sat16(-v) : sat16(v);
            end
            1: begin
                s[0 +: 16]  = sat16(-int'($signed(s[0 +: 16])));
                s[16 +: 16] = sat16(-int'($signed(s[16 +: 16])));
                s[32 +: 16] = sat16(-int'($signed(s[32 +: 16])));
            end
            default: s[47:0] = 48'({$urandom, $urandom});
        endcase
        return s;
    endfunction

    task automatic send_sample(input logic [ipsq_pkg::IN_W-1:0] smp);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(smp);
    endtask

    task automatic write_reg(input logic [ipsq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ipsq_pkg::CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input logic [15:0] tx, ty, tz, cosv, mn, mx, rl, cc);
        write_reg(ipsq_pkg::REG_TARGET_X, tx);
        write_reg(ipsq_pkg::REG_TARGET_Y, ty);
        write_reg(ipsq_pkg::REG_TARGET_Z, tz);
        write_reg(ipsq_pkg::REG_MIN_COSINE, cosv);
        write_reg(ipsq_pkg::REG_MIN_MAGNITUDE, mn);
        write_reg(ipsq_pkg::REG_MAX_MAGNITUDE, mx);
        write_reg(ipsq_pkg::REG_RATE_LIMIT, rl);
        write_reg(ipsq_pkg::REG_CONFIRM_COUNT, cc);
    endtask

    task automatic pick_direction(output logic [15:0] tx, ty, tz);
        real rx, ry, rz, nrm;
        rx = real'(int'($urandom_range(0, 2000)) - 1000);
        ry = real'(int'($urandom_range(0, 2000)) - 1000);
        rz = real'(int'($urandom_range(0, 2000)) - 1000);
        nrm = $sqrt(rx * rx + ry * ry + rz * rz);
        if (nrm == 0.0) begin
            rz  = 1.0;
            nrm = 1.0;
        end
        tx = sat16($rtoi(rx / nrm * 16384.0));
        ty = sat16($rtoi(ry / nrm * 16384.0));
        tz = sat16($rtoi(rz / nrm * 16384.0));
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    initial begin
        logic [ipsq_pkg::IN_W-1:0] smp;
        logic [15:0]               tx, ty, tz;
        int                        sent, len;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        jitter         = 0;
        sb = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        repeat (4) send_sample(good_sample());
        smp = good_sample();
        smp[48 +: 16] = 16'sd1024;
        smp[64 +: 16] = -16'sd1024;
        send_sample(smp);
        smp = good_sample();
        smp[80 +: 16] = 16'sd1025;
        send_sample(smp);
        smp = good_sample();
        smp[48 +: 16] = 16'h8000;
        send_sample(smp);
        send_sample({48'h0, {3{16'h7fff}}});
        send_sample({{3{16'h7fff}}, {3{16'h8000}}});
        send_sample({{3{16'h8000}}, 48'h0});
        send_sample({48'h0, -16'sd480, 16'sd1344, 16'sd1944});
        settle();
        write_reg(ipsq_pkg::REG_MIN_MAGNITUDE, 16'd0);
        send_sample('0);
        settle();
        write_reg(ipsq_pkg::REG_CONFIRM_COUNT, 16'd0);
        repeat (2) send_sample(good_sample());
        settle();
        write_reg(ipsq_pkg::REG_CONFIRM_COUNT, 16'd6);
        repeat (6) send_sample(good_sample());
        settle();
        write_reg(ipsq_pkg::REG_CONFIRM_COUNT, 16'd2);
        send_sample(good_sample());
        settle();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            jitter = $urandom_range(0, 48);
            pick_direction(tx, ty, tz);
            case (phase)
                0: apply_config(ipsq_pkg::RST_TARGET_X, ipsq_pkg::RST_TARGET_Y,
                                ipsq_pkg::RST_TARGET_Z, 16'(ipsq_pkg::RST_MIN_COSINE),
                                16'(ipsq_pkg::RST_MIN_MAGNITUDE),
                                16'(ipsq_pkg::RST_MAX_MAGNITUDE),
                                16'(ipsq_pkg::RST_RATE_LIMIT),
                                16'(ipsq_pkg::RST_CONFIRM_COUNT));
                1: apply_config(16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd32767,
                                16'd32767, 16'd1);
                2: apply_config(tx, ty, tz, 16'($urandom_range(8000, 16000)),
                                16'($urandom_range(0, 3000)), 16'($urandom_range(3000, 32767)),
                                16'($urandom_range(0, 32767)), 16'($urandom_range(1, 15)));
                3: begin
                    jitter = $urandom_range(0, 1);
                    apply_config(16'd0, -16'sd16384, 16'd0, 16'd16384, 16'd100, 16'd20000,
                                 16'd0, 16'd0);
                end
                4: apply_config(tx, ty, tz, 16'd0, 16'd3000, 16'd2000, 16'd500, 16'd3);
                5: apply_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                6: apply_config(tx, ty, tz, 16'd12000, 16'd1000, 16'd30000, 16'd4000, 16'd15);
                default: apply_config(tx, ty, tz, 16'($urandom_range(0, 16384)),
                                      16'($urandom_range(0, 2000)),
                                      16'($urandom_range(2000, 32767)),
                                      16'($urandom_range(0, 32767)),
                                      16'($urandom_range(1, 15)));
            endcase
            sent = 0;
            while (sent < 200) begin
                if ($urandom_range(0, 99) < 70) begin
                    len = $urandom_range(1, int'(sb.need_cfg) + 2);
                    repeat (len) send_sample(good_sample());
                    send_sample(broken_sample());
                    sent += len + 1;
                end else begin
                    send_sample({$urandom, $urandom, $urandom});
                    sent++;
                end
            end
            settle();
        end

        if (sb.errors == 0)
            $display("** imu_pose_stillness_qualifier: PASSED **");
        else
            $display("** imu_pose_stillness_qualifier: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
src/ipsq_pkg.sv
src/ipsq_mac.sv
src/ipsq_run.sv
src/imu_pose_stillness_qualifier.sv
verif/imu_pose_stillness_qualifier_tb.sv
